// ----- hdl/energy_voice_activity_endpointer_assert.svh -----
// ============================================================================
// Assertion macros for the voice activity endpointer
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef ENERGY_VOICE_ACTIVITY_ENDPOINTER_ASSERT_SVH
`define ENERGY_VOICE_ACTIVITY_ENDPOINTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVAE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EVAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/evae_pkg.sv -----
// ============================================================================
// evae_pkg
// Types and constants shared by the voice activity endpointer modules.
// ============================================================================
package evae_pkg;

    // Frame geometry
    localparam int FRAME_LEN   = 400;
    localparam int INIT_FRAMES = 5;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int SEED_W      = $clog2(INIT_FRAMES + 1);

    // Datapath widths
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;
    localparam int ENERGY_W = 42;
    localparam int K_W      = 6;
    localparam int FRAC_W   = 16;
    localparam int DB_W     = 17;
    localparam int RATE_W   = 16;
    localparam int SIL_W    = 8;
    localparam int MUL_W    = 32;

    // Log and rounding constants
    localparam logic [MUL_W-1:0]    LN2X10_Q16 = 32'd454261;
    localparam logic [K_W-1:0]      K_TOP      = K_W'(ENERGY_W - 1);
    localparam logic [DB_W-1:0]     Q16_ONE    = 17'h10000;
    localparam logic [ENERGY_W-1:0] DB_ROUND   = 42'd8388608;
    localparam logic [34:0]         LVL_ROUND  = 35'd32768;
    localparam logic [32:0]         BG_ROUND   = 33'd32768;
    localparam logic [SIL_W-1:0]    SIL_MAX    = 8'd255;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [15:0]      RST_NEW_WEIGHT      = 16'd31208;
    localparam logic [15:0]      RST_BACKGROUND_RATE = 16'd3277;
    localparam logic [DB_W-1:0]  RST_SPEECH_MARGIN   = 17'd3200;
    localparam logic [SIL_W-1:0] RST_SILENCE_LIMIT   = 8'd18;

    typedef enum logic [1:0] {
        REG_NEW_WEIGHT      = 2'd0,
        REG_BACKGROUND_RATE = 2'd1,
        REG_SPEECH_MARGIN   = 2'd2,
        REG_SILENCE_LIMIT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]      new_weight;
        logic [RATE_W-1:0] background_rate;
        logic [DB_W-1:0]  speech_margin;
        logic [SIL_W-1:0] silence_limit;
    } t_cfg;

    // What the back end has to do with a finished frame
    typedef enum logic [1:0] {
        KIND_SEED_ONLY = 2'd0,
        KIND_SEED_LAST = 2'd1,
        KIND_CLASSIFY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [ENERGY_W-1:0] energy;
    } t_frame;

    // Frame queue between front and back end
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

// ----- hdl/energy_voice_activity_endpointer.sv -----
// ============================================================================
// energy_voice_activity_endpointer
// Energy-based voice activity detector that marks the end of an utterance.
// ============================================================================
// The block takes one signed sample per clock while o_stall is low. The front
// end squares it in one register stage and then adds it to the running frame
// energy. Each finished frame goes into a four-entry queue. The back end turns
// the frame energy into dB with a normalizing shifter and sixteen squaring
// steps on one shared 32x32 multiplier. It then updates the level, the
// background and the silent run; the frame that completes the seed only sets
// the background. A frame of zero energy skips the dB conversion, and an
// earlier seeding frame goes straight to the output.
// Input stalls only when the last sample of a frame finds four frames waiting
// in the queue. After the silent run reaches the limit, samples are still
// taken but produce no more results until reset.
// ============================================================================
module energy_voice_activity_endpointer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [evae_pkg::ADDR_W-1:0]           paddr,
    input  logic [evae_pkg::DATA_W-1:0]           pwdata,
    output logic [evae_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [evae_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_frame_is_speech,
    output logic                                  o_seeding,
    output logic [evae_pkg::SIL_W-1:0]            o_silent_run,
    output logic [evae_pkg::DB_W-1:0]             o_level_margin,
    output logic                                  o_speech_over
);
    import evae_pkg::*;

    t_cfg   cfg;
    t_frame q_in;
    t_frame q_out;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;

    evae_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    evae_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    evae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    evae_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_q_empty         (q_empty),
        .i_q_data          (q_out),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_is_speech (o_frame_is_speech),
        .o_seeding         (o_seeding),
        .o_silent_run      (o_silent_run),
        .o_level_margin    (o_level_margin),
        .o_speech_over     (o_speech_over)
    );

endmodule

// ----- hdl/evae_regs.sv -----
// ============================================================================
// evae_regs
// APB-style configuration registers of the voice activity endpointer.
// ============================================================================
module evae_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [evae_pkg::ADDR_W-1:0]  paddr,
    input  logic [evae_pkg::DATA_W-1:0]  pwdata,
    output logic [evae_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output evae_pkg::t_cfg               o_cfg
);
    import evae_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.new_weight      <= RST_NEW_WEIGHT;
            r_cfg.background_rate <= RST_BACKGROUND_RATE;
            r_cfg.speech_margin   <= RST_SPEECH_MARGIN;
            r_cfg.silence_limit   <= RST_SILENCE_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEW_WEIGHT:      r_cfg.new_weight      <= pwdata[15:0];
                REG_BACKGROUND_RATE: r_cfg.background_rate <= pwdata[RATE_W-1:0];
                REG_SPEECH_MARGIN:   r_cfg.speech_margin   <= pwdata[DB_W-1:0];
                REG_SILENCE_LIMIT:   r_cfg.silence_limit   <= pwdata[SIL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEW_WEIGHT:      prdata = DATA_W'(r_cfg.new_weight);
            REG_BACKGROUND_RATE: prdata = DATA_W'(r_cfg.background_rate);
            REG_SPEECH_MARGIN:   prdata = DATA_W'(r_cfg.speech_margin);
            REG_SILENCE_LIMIT:   prdata = DATA_W'(r_cfg.silence_limit);
        endcase
    end

endmodule

// ----- hdl/evae_front.sv -----
// ============================================================================
// evae_front
// Squares samples, accumulates frame energy and sorts finished frames.
// ============================================================================
module evae_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [evae_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output evae_pkg::t_frame                    o_q_data
);
    import evae_pkg::*;

    logic                r_a_valid;
    logic                r_a_last;
    logic [SQ_W-1:0]     r_a_sq;
    logic [POS_W-1:0]    r_pos;
    logic [ENERGY_W-1:0] r_sum;
    logic [SEED_W-1:0]   r_seed;

    logic signed [31:0]  sq_full;
    logic                stuck;
    logic                accept;
    logic                advance;
    logic                pos_last;
    logic [ENERGY_W-1:0] sum_next;
    t_kind               frame_kind;

    assign sq_full  = i_sample * i_sample;
    // A frame-end transaction waits in the square stage until the queue has room.
    assign stuck    = r_a_valid && r_a_last && i_q_full;
    assign o_stall  = stuck;
    assign accept   = i_valid && !stuck;
    assign advance  = r_a_valid && !stuck;
    assign pos_last = (r_pos == POS_W'(FRAME_LEN - 1));
    assign sum_next = r_sum + ENERGY_W'(r_a_sq);

    always_comb begin
        priority if (r_seed >= SEED_W'(INIT_FRAMES)) begin
            frame_kind = KIND_CLASSIFY;
        end else if (r_seed == SEED_W'(INIT_FRAMES - 1)) begin
            frame_kind = KIND_SEED_LAST;
        end else begin
            frame_kind = KIND_SEED_ONLY;
        end
    end

    assign o_q_push        = advance && r_a_last;
    assign o_q_data.kind   = frame_kind;
    assign o_q_data.energy = sum_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_last  <= 1'b0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_seed    <= '0;
        end else begin
            if (!stuck) begin
                r_a_valid <= accept;
            end
            if (accept) begin
                r_a_last <= pos_last;
                r_pos    <= pos_last ? '0 : r_pos + 1'b1;
            end
            if (advance) begin
                // Seeding frames keep adding up until the last one is reached.
                if (!r_a_last || frame_kind == KIND_SEED_ONLY) begin
                    r_sum <= sum_next;
                end else begin
                    r_sum <= '0;
                end
                if (r_a_last && frame_kind != KIND_CLASSIFY) begin
                    r_seed <= r_seed + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_sq <= sq_full[SQ_W-1:0];
        end
    end

endmodule

// ----- hdl/evae_fifo.sv -----
// ============================================================================
// evae_fifo
// Short frame queue between the accumulating front end and the back end.
// ============================================================================
module evae_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  evae_pkg::t_frame i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output evae_pkg::t_frame o_data
);
    import evae_pkg::*;

    t_frame               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_AW:0]     r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- hdl/evae_back.sv -----
// ============================================================================
// evae_back
// Frame-end sequencer: energy to dB, smoothing, background and decision.
// ============================================================================
`include "energy_voice_activity_endpointer_assert.svh"

module evae_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  evae_pkg::t_cfg                 i_cfg,
    input  logic                           i_q_empty,
    input  evae_pkg::t_frame               i_q_data,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_frame_is_speech,
    output logic                           o_seeding,
    output logic [evae_pkg::SIL_W-1:0]     o_silent_run,
    output logic [evae_pkg::DB_W-1:0]      o_level_margin,
    output logic                           o_speech_over
);
    import evae_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_NORM   = 11'b000_0000_0010,
        S_SQR    = 11'b000_0000_0100,
        S_DB     = 11'b000_0000_1000,
        S_DBR    = 11'b000_0001_0000,
        S_APPLY  = 11'b000_0010_0000,
        S_LVL_B  = 11'b000_0100_0000,
        S_LVL_C  = 11'b000_1000_0000,
        S_BG     = 11'b001_0000_0000,
        S_DECIDE = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_kind               r_kind;
    logic [ENERGY_W-1:0] r_m42;
    logic [K_W-1:0]      r_k;
    logic [SQ_W-1:0]     r_m;
    logic [FRAC_W-1:0]   r_frac;
    logic [3:0]          r_bit;
    logic [2*MUL_W-1:0]  r_prod;
    logic [34:0]         r_acc;
    logic [DB_W-1:0]     r_cur;
    logic [DB_W-1:0]     r_level;
    logic [DB_W-1:0]     r_bg;
    logic [SIL_W-1:0]    r_sil;
    logic                r_ended;
    logic                r_res_speech;
    logic                r_res_seeding;
    logic [DB_W-1:0]     r_res_margin;
    logic                r_out_valid;
    logic                r_out_speech;
    logic                r_out_seeding;
    logic [SIL_W-1:0]    r_out_sil;
    logic [DB_W-1:0]     r_out_margin;
    logic                r_out_ended;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    logic                slot_free;
    logic                q_take;
    logic [ENERGY_W-1:0] db_round;
    logic [34:0]         lvl_sum;
    logic [32:0]         bg_sum;
    logic [DB_W-1:0]     dec_level;
    logic [DB_W-1:0]     dec_margin;
    logic                dec_speech;
    logic [SIL_W-1:0]    dec_sil;

    assign slot_free = !r_out_valid || !i_stall;
    assign q_take    = (r_state == S_IDLE) && !i_q_empty;
    assign o_q_pop   = q_take;

    // One multiplier serves the log squaring, the dB scaling and the updates.
    always_comb begin
        unique case (r_state)
            S_SQR: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            S_DB: begin
                mul_a = MUL_W'({r_k, r_frac});
                mul_b = LN2X10_Q16;
            end
            S_APPLY: begin
                mul_a = MUL_W'(r_level);
                mul_b = MUL_W'(Q16_ONE - {1'b0, i_cfg.new_weight});
            end
            S_LVL_B: begin
                mul_a = MUL_W'(r_cur);
                mul_b = MUL_W'(i_cfg.new_weight);
            end
            S_LVL_C: begin
                mul_a = MUL_W'(r_cur - r_bg);
                mul_b = MUL_W'(i_cfg.background_rate);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign db_round = r_prod[ENERGY_W-1:0] + DB_ROUND;
    assign lvl_sum  = r_acc + r_prod[34:0] + LVL_ROUND;
    assign bg_sum   = r_prod[32:0] + BG_ROUND;

    always_comb begin
        dec_level  = (r_level < r_bg) ? r_bg : r_level;
        dec_margin = dec_level - r_bg;
        dec_speech = (dec_margin > i_cfg.speech_margin);
        if (dec_speech) begin
            dec_sil = '0;
        end else if (r_sil != SIL_MAX) begin
            dec_sil = r_sil + 1'b1;
        end else begin
            dec_sil = r_sil;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (q_take && !r_ended) begin
                    priority if (i_q_data.kind == KIND_SEED_ONLY) begin
                        n_state = S_OUT;
                    end else if (i_q_data.energy == '0) begin
                        n_state = S_APPLY;
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM:   n_state = r_m42[ENERGY_W-1] ? S_SQR : S_NORM;
            S_SQR:    n_state = (r_bit == '0) ? S_DB : S_SQR;
            S_DB:     n_state = S_DBR;
            S_DBR:    n_state = S_APPLY;
            S_APPLY:  n_state = (r_kind == KIND_SEED_LAST) ? S_OUT : S_LVL_B;
            S_LVL_B:  n_state = S_LVL_C;
            S_LVL_C:  n_state = S_BG;
            S_BG:     n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_OUT:    n_state = slot_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_bg        <= '0;
            r_sil       <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY && r_kind == KIND_SEED_LAST) begin
                r_bg <= r_cur;
            end
            if (r_state == S_LVL_C) begin
                r_level <= lvl_sum[32:16];
            end
            if (r_state == S_BG) begin
                if (r_cur < r_bg) begin
                    r_bg <= r_cur;
                end else begin
                    r_bg <= r_bg + bg_sum[32:16];
                end
            end
            if (r_state == S_DECIDE) begin
                r_level <= dec_level;
                r_sil   <= dec_sil;
                r_ended <= (dec_sil >= i_cfg.silence_limit);
            end
            if (r_state == S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_kind        <= i_q_data.kind;
                r_m42         <= i_q_data.energy;
                r_k           <= K_TOP;
                r_frac        <= '0;
                r_bit         <= 4'd15;
                r_cur         <= '0;
                r_res_speech  <= 1'b0;
                r_res_seeding <= 1'b1;
                r_res_margin  <= '0;
            end
            S_NORM: begin
                // Coarse byte steps first, then single bits, to bring the top one up.
                if (r_m42[ENERGY_W-1]) begin
                    r_m <= r_m42[ENERGY_W-1:ENERGY_W-SQ_W];
                end else if (r_m42[ENERGY_W-1:ENERGY_W-8] == '0) begin
                    r_m42 <= r_m42 << 8;
                    r_k   <= r_k - K_W'(8);
                end else begin
                    r_m42 <= r_m42 << 1;
                    r_k   <= r_k - 1'b1;
                end
            end
            S_SQR: begin
                // Squaring the Q1.30 mantissa yields one fraction bit of log2.
                r_frac <= {r_frac[FRAC_W-2:0], mul_p[61]};
                r_m    <= mul_p[61] ? mul_p[61:31] : mul_p[60:30];
                r_bit  <= r_bit - 1'b1;
            end
            S_DB: begin
                r_prod <= mul_p;
            end
            S_DBR: begin
                r_cur <= db_round[40:24];
            end
            S_APPLY: begin
                r_prod <= mul_p;
            end
            S_LVL_B: begin
                r_acc  <= r_prod[34:0];
                r_prod <= mul_p;
            end
            S_LVL_C: begin
                r_prod <= mul_p;
            end
            S_BG: begin
            end
            S_DECIDE: begin
                r_res_speech  <= dec_speech;
                r_res_seeding <= 1'b0;
                r_res_margin  <= dec_margin;
            end
            S_OUT: begin
                if (slot_free) begin
                    r_out_speech  <= r_res_speech;
                    r_out_seeding <= r_res_seeding;
                    r_out_sil     <= r_sil;
                    r_out_margin  <= r_res_margin;
                    r_out_ended   <= r_ended;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_frame_is_speech = r_out_speech;
    assign o_seeding         = r_out_seeding;
    assign o_silent_run      = r_out_sil;
    assign o_level_margin    = r_out_margin;
    assign o_speech_over     = r_out_ended;

    `EVAE_ASSERT_NEXT(a_ended_sticky, r_ended, r_ended, "end of utterance was cleared")
    `EVAE_ASSERT_NEXT(a_idle_after_end, r_ended && r_state == S_IDLE, r_state == S_IDLE, "sequencer started a frame after the end")
    `EVAE_ASSERT_NOW(a_seed_result, r_out_valid && r_out_seeding, !r_out_speech && r_out_margin == '0, "seeding frame carried a decision")
    `EVAE_ASSERT_NOW(a_speech_run, r_out_valid && r_out_speech, r_out_sil == '0, "speech frame left a silent run")

endmodule

// ----- verif/tb_energy_voice_activity_endpointer.sv -----
// ============================================================================
// tb_energy_voice_activity_endpointer
// Self-checking bench for the energy-based voice activity endpointer.
// ============================================================================
// Samples are driven over the valid/stall channel. An internal frame predictor
// tracks energy, log conversion, level and background smoothing and the silent
// run, and every frame result from the block is compared field by field.
// The register port is exercised through reset readback, extreme settings,
// speech frames at a silence limit of one, and a long silence that ends
// the utterance. After that, samples must produce no further results.
// ============================================================================
`timescale 1ns / 1ps

module tb_energy_voice_activity_endpointer;

    import evae_pkg::*;

    localparam int BACKEND_SETTLE = 100;

    typedef struct packed {
        logic             frame_is_speech;
        logic             seeding;
        logic [SIL_W-1:0] silent_run;
        logic [DB_W-1:0]  level_margin;
        logic             speech_over;
    } t_frame_verdict;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_frame_is_speech;
    logic                       o_seeding;
    logic [SIL_W-1:0]           o_silent_run;
    logic [DB_W-1:0]            o_level_margin;
    logic                       o_speech_over;

    energy_voice_activity_endpointer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_is_speech (o_frame_is_speech),
        .o_seeding         (o_seeding),
        .o_silent_run      (o_silent_run),
        .o_level_margin    (o_level_margin),
        .o_speech_over     (o_speech_over)
    );

    // Predictor state and configuration
    t_cfg              cfg;
    logic [ENERGY_W-1:0] acc_energy;
    int unsigned       frame_pos;
    int unsigned       seeds_done;
    logic [DB_W-1:0]   level_q8;
    logic [DB_W-1:0]   backgr_q8;
    logic [SIL_W-1:0]  silent_frames;
    bit                utterance_done;

    t_frame_verdict    pending_verdicts[$];

    int fault_count;
    int samples_sent;
    int frames_predicted;
    int frames_checked;
    int seeding_seen;
    int speech_seen;
    int send_idle_pct;
    int recv_stall_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // 10*ln(E) in Q9.8 via a normalized log2 with one bit per squaring step.
    function automatic logic [DB_W-1:0] frame_energy_db(input logic [ENERGY_W-1:0] e);
        int          k;
        logic [63:0] m;
        logic [63:0] lg;
        if (e == '0)
            return '0;
        k = 0;
        for (int b = ENERGY_W - 1; b >= 0; b--) begin
            if (e[b]) begin
                k = b;
                break;
            end
        end
        if (k <= 30)
            m = {22'b0, e} << (30 - k);
        else
            m = {22'b0, e} >> (k - 30);
        lg = 64'(k) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                lg[i] = 1'b1;
                m = m >> 1;
            end
        end
        return DB_W'((lg * 64'd454261 + (64'd1 << 23)) >> 24);
    endfunction

    task automatic track_sample(input logic signed [SAMPLE_W-1:0] smp);
        logic [16:0]    mag;
        logic [DB_W-1:0] cur;
        logic [63:0]    acc64;
        t_frame_verdict v;
        if (utterance_done)
            return;
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        acc64 = 64'(mag) * 64'(mag);
        acc_energy = ENERGY_W'(64'(acc_energy) + acc64);
        if (frame_pos + 1 < FRAME_LEN) begin
            frame_pos++;
            return;
        end
        frame_pos = 0;
        v = '0;
        if (seeds_done < INIT_FRAMES) begin
            v.seeding = 1'b1;
            seeds_done++;
            if (seeds_done >= INIT_FRAMES) begin
                backgr_q8 = frame_energy_db(acc_energy);
                acc_energy = '0;
            end
        end else begin
            cur = frame_energy_db(acc_energy);
            acc_energy = '0;
            acc64 = 64'(level_q8) * (64'd65536 - 64'(cfg.new_weight))
                  + 64'(cur) * 64'(cfg.new_weight) + 64'd32768;
            level_q8 = DB_W'(acc64 >> 16);
            if (cur < backgr_q8) begin
                backgr_q8 = cur;
            end else begin
                acc64 = (64'(cur - backgr_q8) * 64'(cfg.background_rate) + 64'd32768) >> 16;
                backgr_q8 = DB_W'(64'(backgr_q8) + acc64);
            end
            if (level_q8 < backgr_q8)
                level_q8 = backgr_q8;
            v.level_margin = level_q8 - backgr_q8;
            if (v.level_margin > cfg.speech_margin) begin
                v.frame_is_speech = 1'b1;
                silent_frames = '0;
            end else if (silent_frames != SIL_MAX) begin
                silent_frames++;
            end
            if (silent_frames >= cfg.silence_limit)
                utterance_done = 1'b1;
        end
        v.silent_run = silent_frames;
        v.speech_over = utterance_done;
        pending_verdicts.push_back(v);
        frames_predicted++;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_checker
        t_frame_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("frame result arrived with no frame pending");
                fault_count++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("frame_is_speech", want.frame_is_speech, o_frame_is_speech);
                check_field("seeding", want.seeding, o_seeding);
                check_field("silent_run", want.silent_run, o_silent_run);
                check_field("level_margin", want.level_margin, o_level_margin);
                check_field("speech_over", want.speech_over, o_speech_over);
                frames_checked++;
                if (o_seeding)
                    seeding_seen++;
                if (o_frame_is_speech)
                    speech_seen++;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // One sample transaction; valid stays high afterwards until the next call
    // or until the back end is drained.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        samples_sent++;
        track_sample(smp);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample(input int amp);
        if (amp >= 32768)
            return SAMPLE_W'($urandom());
        return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    function automatic int random_amplitude();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 3;
            2: return 60;
            3: return 1500;
            default: return 32768;
        endcase
    endfunction

    task automatic send_burst(input int count, input int amp);
        for (int n = 0; n < count; n++)
            send_sample(random_sample(amp));
    endtask

    task automatic random_bursts(input int frames_wanted);
        int start;
        start = frames_predicted;
        while (frames_predicted - start < frames_wanted && !utterance_done)
            send_burst($urandom_range(1, 600), random_amplitude());
    endtask

    // Hold off the sender until every frame result is in and the back end
    // has had time to settle.
    task automatic wait_backend_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (BACKEND_SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic is_write, input t_reg_idx idx,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] held;
        logic [DATA_W-1:0] unused;
        case (idx)
            REG_NEW_WEIGHT: begin
                cfg.new_weight = value[15:0];
                held = DATA_W'(cfg.new_weight);
            end
            REG_BACKGROUND_RATE: begin
                cfg.background_rate = value[RATE_W-1:0];
                held = DATA_W'(cfg.background_rate);
            end
            REG_SPEECH_MARGIN: begin
                cfg.speech_margin = value[DB_W-1:0];
                held = DATA_W'(cfg.speech_margin);
            end
            default: begin
                cfg.silence_limit = value[SIL_W-1:0];
                held = DATA_W'(cfg.silence_limit);
            end
        endcase
        apb_access(1'b1, idx, value, unused);
        apb_access(1'b0, idx, '0, unused);
        check_field(idx.name(), held, unused);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] weight,
                                  input logic [DATA_W-1:0] rate,
                                  input logic [DATA_W-1:0] margin,
                                  input logic [DATA_W-1:0] limit);
        wait_backend_idle();
        write_reg(REG_NEW_WEIGHT, weight);
        write_reg(REG_BACKGROUND_RATE, rate);
        write_reg(REG_SPEECH_MARGIN, margin);
        write_reg(REG_SILENCE_LIMIT, limit);
    endtask

    task automatic test_register_defaults();
        logic [DATA_W-1:0] got;
        apb_access(1'b0, REG_NEW_WEIGHT, '0, got);
        check_field("reset new_weight", RST_NEW_WEIGHT, got);
        apb_access(1'b0, REG_BACKGROUND_RATE, '0, got);
        check_field("reset background_rate", RST_BACKGROUND_RATE, got);
        apb_access(1'b0, REG_SPEECH_MARGIN, '0, got);
        check_field("reset speech_margin", RST_SPEECH_MARGIN, got);
        apb_access(1'b0, REG_SILENCE_LIMIT, '0, got);
        check_field("reset silence_limit", RST_SILENCE_LIMIT, got);
    endtask

    // Sample extremes open the first seeding frame; after seeding, one frame of
    // zero energy and one at full negative scale get classified.
    task automatic test_seeding_and_extremes();
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_burst(INIT_FRAMES * FRAME_LEN - 7, 32768);
        send_burst(FRAME_LEN, 0);
        for (int n = 0; n < FRAME_LEN; n++)
            send_sample(-16'sd32768);
    endtask

    task automatic test_default_random();
        random_bursts(15);
    endtask

    task automatic test_register_sweep();
        apply_settings(32'd0, 32'd65535, 32'd0, 32'd255);
        random_bursts(8);
        apply_settings(32'd65535, 32'd0, 32'd131071, 32'd230);
        random_bursts(8);
        // Upper bits beyond each register's width must be dropped.
        apply_settings({16'($urandom()), 16'($urandom())}, {16'hFFFF, 16'($urandom())},
                       {15'h7FFF, 17'($urandom_range(0, 6000))}, $urandom_range(200, 255));
        random_bursts(8);
        apply_settings(32'd32768, 32'd1, 32'd1, 32'd255);
        random_bursts(8);
        apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 6000), $urandom_range(200, 255));
        random_bursts(8);
    endtask

    // With the background frozen and a zero margin, loud frames after a quiet
    // one stay speech, so a limit of one does not end the utterance.
    task automatic test_speech_at_limit_one();
        apply_settings(32'd65535, 32'd0, 32'd0, 32'd255);
        send_burst(FRAME_LEN - frame_pos, 3);
        wait_backend_idle();
        write_reg(REG_SILENCE_LIMIT, 32'd1);
        send_burst(3 * FRAME_LEN, 32768);
    endtask

    // Silence at the longest limit runs the silent count up to its ceiling;
    // afterwards samples must be ignored.
    task automatic test_silence_to_end();
        int frames;
        apply_settings(32'd65535, 32'd3277, 32'd3200, 32'd255);
        frames = 0;
        while (!utterance_done && frames < 300) begin
            send_burst(FRAME_LEN, 0);
            frames++;
        end
        send_burst(FRAME_LEN + 50, 32768);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_valid  = 1'b0;
        i_sample = '0;
        i_stall  = 1'b0;
        cfg.new_weight      = RST_NEW_WEIGHT;
        cfg.background_rate = RST_BACKGROUND_RATE;
        cfg.speech_margin   = RST_SPEECH_MARGIN;
        cfg.silence_limit   = RST_SILENCE_LIMIT;
        acc_energy       = '0;
        frame_pos        = 0;
        seeds_done       = 0;
        level_q8         = '0;
        backgr_q8        = '0;
        silent_frames    = '0;
        utterance_done   = 1'b0;
        fault_count      = 0;
        samples_sent     = 0;
        frames_predicted = 0;
        frames_checked   = 0;
        seeding_seen     = 0;
        speech_seen      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();

        send_idle_pct  = 35;
        recv_stall_pct = 57;
        test_seeding_and_extremes();
        test_default_random();

        send_idle_pct  = 57;
        recv_stall_pct = 35;
        test_register_sweep();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_speech_at_limit_one();
        test_silence_to_end();

        wait_backend_idle();
        $display("Covered %0d samples and %0d frame results (%0d seeding, %0d speech).",
                 samples_sent, frames_checked, seeding_seen, speech_seen);
        $display("Swept register extremes; final silent run %0d, utterance ended: %0d.",
                 silent_frames, utterance_done);
        if (fault_count == 0 && pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
